// ===== rtl/core/esr_pkg.sv =====
// ----------------------------------------------------------------------------
// Ellipse span rasterizer package
// Shared widths, types and constants of the ellipse span rasterizer.
// ----------------------------------------------------------------------------
package esr_pkg;

    localparam int CX_W     = 12;
    localparam int RX_W     = 8;
    localparam int RY_W     = 5;
    localparam int COL_W    = 8;
    localparam int SPX_W    = 13;
    localparam int SPW_W    = 9;
    localparam int DY_W     = RY_W + 2;
    localparam int SQ_W     = 2 * RY_W;
    localparam int PROD_W   = RX_W + RY_W;
    localparam int HALF_W   = RX_W;
    localparam int RY_MAX_DEF = 31;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_ROOT  = 5'b00100,
        S_MDIV  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

// ===== rtl/core/esr_isqrt.sv =====
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring square root that consumes two radicand bits per cycle.
// ----------------------------------------------------------------------------
module esr_isqrt
    import esr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_W-1:0]     i_radicand,
    output t_unit_stat          o_stat,
    output logic [RY_W-1:0]     o_root
);

    localparam int ITER  = SQ_W / 2;
    localparam int CNT_W = $clog2(ITER);
    localparam int REM_W = RY_W + 3;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SQ_W-1:0]    r_rad, n_rad;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [RY_W-1:0]    r_root, n_root;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ITER - 1);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[RY_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[RY_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

`ifndef SYNTH
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("square root finished without a running pass");
`endif

endmodule

// ===== rtl/core/esr_muldiv.sv =====
// ----------------------------------------------------------------------------
// Serial multiply and divide
// Shift-add product of the horizontal radius and the root, then restoring
// division by the vertical radius, one bit per cycle.
// ----------------------------------------------------------------------------
module esr_muldiv
    import esr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RX_W-1:0]     i_mcand,
    input  logic [RY_W-1:0]     i_mplier,
    input  logic [RY_W-1:0]     i_divisor,
    output t_unit_stat          o_stat,
    output logic [HALF_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2((RY_W > HALF_W) ? RY_W : HALF_W);

    logic               r_busy, n_busy;
    logic               r_div, n_div;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [RX_W-1:0]    r_mcand, n_mcand;
    logic [RY_W-1:0]    r_mpl, n_mpl;
    logic [RY_W-1:0]    r_dvs, n_dvs;
    logic [PROD_W-1:0]  r_acc, n_acc;
    logic [RY_W-1:0]    r_rem, n_rem;
    logic [HALF_W-1:0]  r_q, n_q;
    logic [PROD_W-1:0]  sum;
    logic [RY_W:0]      rem_sh;

    assign sum    = {r_acc[PROD_W-2:0], 1'b0}
                  + (r_mpl[RY_W-1] ? PROD_W'(r_mcand) : PROD_W'(0));
    assign rem_sh = {r_rem, r_q[HALF_W-1]};

    always_comb begin
        n_busy  = r_busy;
        n_div   = r_div;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_mpl   = r_mpl;
        n_dvs   = r_dvs;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_q     = r_q;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_div   = 1'b0;
            n_cnt   = CNT_W'(RY_W - 1);
            n_mcand = i_mcand;
            n_mpl   = i_mplier;
            n_dvs   = i_divisor;
            n_acc   = '0;
        end else if (r_busy && !r_div) begin
            n_acc = sum;
            n_mpl = {r_mpl[RY_W-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_div = 1'b1;
                n_cnt = CNT_W'(HALF_W - 1);
                n_rem = sum[PROD_W-1 -: RY_W];
                n_q   = sum[HALF_W-1:0];
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = RY_W'(rem_sh - {1'b0, r_dvs});
                n_q   = {r_q[HALF_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[RY_W-1:0];
                n_q   = {r_q[HALF_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_div  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_div  <= n_div;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand <= n_mcand;
        r_mpl   <= n_mpl;
        r_dvs   <= n_dvs;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_q     <= n_q;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

`ifndef SYNTH
    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_dvs != '0)
        else $error("division started with a zero divisor");
`endif

endmodule

// ===== rtl/core/ellipse_span_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Ellipse span rasterizer
// Turns one filled-ellipse item into one horizontal span per row.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. busy stays
// high until the last span of the item has been given. Spans come out one at
// a time, rows from top to bottom, each shown for a single cycle with
// o_span_valid high; o_last_span marks the final one. The receiver cannot
// stall the block, so every span must be taken in its cycle.
// Each row runs a serial square root, then a serial multiply and divide,
// one bit or one two-bit digit per cycle, between a setup state and the
// emit state. An item with vertical radius r gives 2r+1 rows; with r = 0
// the single span is given in the cycle after accept. The next item may
// be accepted the cycle after the last span.
// Reset is synchronous and returns the block to idle; any item in flight is
// dropped.
// ----------------------------------------------------------------------------
module ellipse_span_rasterizer_top
    import esr_pkg::*;
#(
    parameter int MAX_RADIUS_Y = RY_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CX_W-1:0]  i_centre_x,
    input  logic signed [CX_W-1:0]  i_centre_y,
    input  logic [RX_W-1:0]         i_radius_x,
    input  logic [RY_W-1:0]         i_radius_y,
    input  logic [COL_W-1:0]        i_fill_colour,
    output logic                    o_span_valid,
    output logic signed [SPX_W-1:0] o_span_x,
    output logic signed [SPX_W-1:0] o_span_y,
    output logic [SPW_W-1:0]        o_span_width,
    output logic [COL_W-1:0]        o_span_colour,
    output logic                    o_last_span
);

    t_state                 r_state, n_state;
    logic [CX_W-1:0]        r_cx, n_cx;
    logic [CX_W-1:0]        r_cy, n_cy;
    logic [RX_W-1:0]        r_rx, n_rx;
    logic [RY_W-1:0]        r_ry, n_ry;
    logic [COL_W-1:0]       r_col, n_col;
    logic [DY_W-1:0]        r_dy, n_dy;
    logic [HALF_W-1:0]      r_half, n_half;

    logic                   accept;
    logic [RY_W-1:0]        ry_sat;
    logic [RY_W-1:0]        ady;
    logic [SQ_W-1:0]        radicand;
    logic                   is_last;
    t_unit_stat             root_stat;
    t_unit_stat             md_stat;
    logic [RY_W-1:0]        root;
    logic [HALF_W-1:0]      quot;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign ry_sat  = (i_radius_y > RY_W'(MAX_RADIUS_Y)) ? RY_W'(MAX_RADIUS_Y) : i_radius_y;
    assign ady     = r_dy[DY_W-1] ? RY_W'(-r_dy) : r_dy[RY_W-1:0];
    assign radicand = ({{(SQ_W-RY_W){1'b0}}, r_ry} * {{(SQ_W-RY_W){1'b0}}, r_ry})
                    - ({{(SQ_W-RY_W){1'b0}}, ady} * {{(SQ_W-RY_W){1'b0}}, ady});
    assign is_last = (r_dy == {2'b00, r_ry});

    esr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SETUP),
        .i_radicand (radicand),
        .o_stat     (root_stat),
        .o_root     (root)
    );

    esr_muldiv u_muldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_ROOT) && root_stat.done),
        .i_mcand    (r_rx),
        .i_mplier   (root),
        .i_divisor  (r_ry),
        .o_stat     (md_stat),
        .o_quot     (quot)
    );

    always_comb begin
        n_state = r_state;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_col   = r_col;
        n_dy    = r_dy;
        n_half  = r_half;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cx  = i_centre_x;
                    n_cy  = i_centre_y;
                    n_rx  = i_radius_x;
                    n_ry  = ry_sat;
                    n_col = i_fill_colour;
                    n_dy  = -{2'b00, ry_sat};
                    if (ry_sat == '0) begin
                        n_half  = i_radius_x;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (root_stat.done) begin
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                if (md_stat.done) begin
                    n_half  = quot;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (is_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_dy    = r_dy + 1'b1;
                    n_state = S_SETUP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dy    <= '0;
        end else begin
            r_state <= n_state;
            r_dy    <= n_dy;
        end
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_col  <= n_col;
        r_half <= n_half;
    end

    assign o_span_valid  = (r_state == S_EMIT);
    assign o_span_x      = $signed({r_cx[CX_W-1], r_cx}) - $signed({5'b00000, r_half});
    assign o_span_y      = $signed({r_cy[CX_W-1], r_cy})
                         + $signed({{(SPX_W-DY_W){r_dy[DY_W-1]}}, r_dy});
    assign o_span_width  = {r_half, 1'b0};
    assign o_span_colour = r_col;
    assign o_last_span   = is_last;

`ifndef SYNTH
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span_valid && o_last_span |=> !busy)
        else $error("block still busy after the last span");
    a_spans_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span_valid && !o_last_span |=> !o_span_valid && busy)
        else $error("span sequence broken");
`endif

endmodule
